[design/rgce_pkg.sv]
// Shared types and constants for the rectangle grid cell enumerator.
// No dependencies; every other design file imports this package.
package rgce_pkg;

  localparam int COORD_W   = 24;  // rectangle coordinate width
  localparam int FRAC_BITS = 8;   // fraction bits of the coordinates
  localparam int CELL_W    = 16;  // cell index width
  localparam int CSIZE_W   = 13;  // cell size register width
  localparam int NUM_W     = COORD_W - FRAC_BITS + 1;  // whole-unit dividend, signed
  localparam int MAG_W     = NUM_W - 1;                // dividend magnitude
  localparam int S_DATA_W  = 4 * COORD_W + 2 * CELL_W;
  localparam int M_DATA_W  = 2 * CELL_W;
  localparam int M_USER_W  = 2;
  localparam int USER_FB    = 0;
  localparam int USER_TRUNC = 1;

  // register index; the register sits at byte address 4 * index
  localparam logic REG_CELL_SIZE = 1'b0;

  localparam logic [CSIZE_W-1:0] CELL_SIZE_RST = CSIZE_W'(32);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_ISSUE,
    ST_DIV_WAIT,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    OP_COL_FIRST,
    OP_ROW_FIRST,
    OP_COL_FINAL,
    OP_ROW_FINAL
  } op_t;

  typedef struct packed {
    logic              start_fb;
    logic [CELL_W-1:0] fb_x;
    logic [CELL_W-1:0] fb_y;
    logic              load;
    op_t               op;
    logic [CELL_W-1:0] value;
    logic              advance;
  } scan_ctrl_t;

  typedef struct packed {
    logic [CELL_W-1:0] x;
    logic [CELL_W-1:0] y;
    logic              last;
    logic              fb;
    logic              trunc;
  } scan_out_t;

endpackage

[design/rgce_div.sv]
// Shared iterative floor divider: signed whole-unit coordinate by cell size.
// One quotient bit per cycle, saturated to the cell index range. Uses rgce_pkg.
module rgce_div import rgce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [CSIZE_W-1:0]      den,
  output logic                    done,
  output logic [CELL_W-1:0]       quo
);

  localparam int STEP_W = $clog2(MAG_W);

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic                neg;
  logic [MAG_W-1:0]    mag;
  logic [MAG_W-1:0]    q;
  logic [CSIZE_W-1:0]  rem;
  logic [CSIZE_W-1:0]  div_r;
  logic [CSIZE_W:0]    rem_sh;
  logic                fits;
  logic [CSIZE_W:0]    rem_sub;
  logic [NUM_W-1:0]    res;

  // floor(n/d) for negative n equals ~((~n)/d), so only a magnitude divide is needed
  assign rem_sh  = {rem, mag[MAG_W-1]};
  assign fits    = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start && !busy) begin
        busy  <= 1'b1;
        step  <= '0;
        neg   <= num[NUM_W-1];
        mag   <= num[NUM_W-1] ? ~num[MAG_W-1:0] : num[MAG_W-1:0];
        div_r <= (den == '0) ? CSIZE_W'(1) : den;
        rem   <= '0;
        q     <= '0;
      end else if (busy) begin
        mag  <= {mag[MAG_W-2:0], 1'b0};
        q    <= {q[MAG_W-2:0], fits};
        rem  <= fits ? rem_sub[CSIZE_W-1:0] : rem_sh[CSIZE_W-1:0];
        step <= step + STEP_W'(1);
        if (step == STEP_W'(MAG_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    res = neg ? ~{1'b0, q} : {1'b0, q};
    if (res[NUM_W-1] == res[NUM_W-2]) begin
      quo = res[CELL_W-1:0];
    end else if (res[NUM_W-1]) begin
      quo = {1'b1, {(CELL_W-1){1'b0}}};
    end else begin
      quo = {1'b0, {(CELL_W-1){1'b1}}};
    end
  end

endmodule

[design/rgce_scan.sv]
// Cell range registers and scan cursor; forms the current result and its flags.
// Driven by the sequencer in the top level. Uses rgce_pkg.
module rgce_scan import rgce_pkg::*; #(
  parameter int MAX_CELLS = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  scan_ctrl_t ctrl,
  output scan_out_t  res
);

  localparam int CNT_W = $clog2(MAX_CELLS + 1);

  logic [CELL_W-1:0] col_first;
  logic [CELL_W-1:0] col_final;
  logic [CELL_W-1:0] row_final;
  logic [CELL_W-1:0] col_now;
  logic [CELL_W-1:0] row_now;
  logic [CNT_W-1:0]  emitted_count;
  logic              fb;
  logic              end_of_range;
  logic              full;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_first     <= '0;
      col_final     <= '0;
      row_final     <= '0;
      col_now       <= '0;
      row_now       <= '0;
      emitted_count <= '0;
      fb            <= 1'b0;
    end else if (ctrl.start_fb) begin
      col_now       <= ctrl.fb_x;
      row_now       <= ctrl.fb_y;
      fb            <= 1'b1;
      emitted_count <= '0;
    end else if (ctrl.load) begin
      unique case (ctrl.op)
        OP_COL_FIRST: begin
          col_first     <= ctrl.value;
          col_now       <= ctrl.value;
          fb            <= 1'b0;
          emitted_count <= '0;
        end
        OP_ROW_FIRST: row_now   <= ctrl.value;
        OP_COL_FINAL: col_final <= ctrl.value;
        OP_ROW_FINAL: row_final <= ctrl.value;
        default: ;
      endcase
    end else if (ctrl.advance) begin
      emitted_count <= emitted_count + CNT_W'(1);
      if (col_now == col_final) begin
        col_now <= col_first;
        row_now <= row_now + CELL_W'(1);
      end else begin
        col_now <= col_now + CELL_W'(1);
      end
    end
  end

  assign end_of_range = (col_now == col_final) && (row_now == row_final);
  assign full         = emitted_count == CNT_W'(MAX_CELLS - 1);

  assign res.x     = col_now;
  assign res.y     = row_now;
  assign res.last  = fb || end_of_range || full;
  assign res.fb    = fb;
  assign res.trunc = !fb && full && !end_of_range;

endmodule

[design/rect_grid_cell_enumerator_top.sv]
// Top level of the rectangle grid cell enumerator: APB register, stream ports,
// sequencer. Instantiates rgce_div and rgce_scan; uses rgce_pkg.
//
//  Port group   Dir  Width  Contents
//  s_t*         in   128    one rectangle request plus its fallback cell
//  m_t*         out  32+2   one grid cell per beat, tlast on the final one
//  APB          in   32     cell_size register at byte address 0
//
// Flow: a request with zero or negative width or height shows its single
// fallback result on the cycle after acceptance. Otherwise the shared divider
// runs four floor divisions one after another, each an issue step, 16 quotient
// bits and a done step; results then leave at one per cycle, up to MAX_CELLS.
// s_tready is high only while idle. A low m_tready holds the current result.
// Reset: synchronous, clears the sequencer and the cell range; cell_size to 32.
module rect_grid_cell_enumerator_top import rgce_pkg::*; #(
  parameter int MAX_CELLS = 64
) (
  input  logic                clk,
  input  logic                rst,
  // request stream
  input  logic                s_tvalid,
  output logic                s_tready,
  // [23:0] rect_left, [47:24] rect_top, [71:48] rect_width,
  // [95:72] rect_height, [111:96] fallback_x, [127:112] fallback_y
  input  logic [S_DATA_W-1:0] s_tdata,
  // result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,  // [15:0] cell_x, [31:16] cell_y
  output logic                m_tlast,  // last_cell
  output logic [M_USER_W-1:0] m_tuser,  // [0] used_fallback, [1] truncated
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  state_t                  state, state_next;
  op_t                     op_sel;
  logic [CSIZE_W-1:0]      cell_size;
  logic signed [NUM_W-1:0] num [4];

  logic                    s_acc;
  logic                    m_acc;
  logic                    empty;
  logic                    div_start;
  logic                    div_done;
  logic [CELL_W-1:0]       div_quo;
  scan_ctrl_t              ctrl;
  scan_out_t               res;

  // request fields
  logic signed [COORD_W-1:0] in_left, in_top, in_w, in_h;
  logic [COORD_W:0]          left_x, top_x, col_end, row_end;

  assign in_left = s_tdata[COORD_W-1:0];
  assign in_top  = s_tdata[2*COORD_W-1:COORD_W];
  assign in_w    = s_tdata[3*COORD_W-1:2*COORD_W];
  assign in_h    = s_tdata[4*COORD_W-1:3*COORD_W];

  // far edge pulled in by one LSB so an edge on a cell border stays in the near cell
  assign left_x  = {in_left[COORD_W-1], in_left};
  assign top_x   = {in_top[COORD_W-1], in_top};
  assign col_end = left_x + {in_w[COORD_W-1], in_w} - (COORD_W + 1)'(1);
  assign row_end = top_x + {in_h[COORD_W-1], in_h} - (COORD_W + 1)'(1);

  assign empty = in_w[COORD_W-1] || (in_w == '0) || in_h[COORD_W-1] || (in_h == '0);
  assign s_acc = s_tvalid && s_tready;
  assign m_acc = m_tvalid && m_tready;

  // APB register; the cell edge in fixed point is cell_size << FRAC_BITS, so
  // dividing the whole-unit part of a coordinate by cell_size gives the same floor
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size <= CELL_SIZE_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CELL_SIZE) begin
      cell_size <= pwdata[CSIZE_W-1:0];
    end
  end
  assign prdata = (paddr[2] == REG_CELL_SIZE) ? {{(32-CSIZE_W){1'b0}}, cell_size} : '0;

  // capture the four dividends when a request is taken
  always_ff @(posedge clk) begin
    if (s_acc) begin
      num[OP_COL_FIRST] <= left_x[COORD_W:FRAC_BITS];
      num[OP_ROW_FIRST] <= top_x[COORD_W:FRAC_BITS];
      num[OP_COL_FINAL] <= col_end[COORD_W:FRAC_BITS];
      num[OP_ROW_FINAL] <= row_end[COORD_W:FRAC_BITS];
    end
  end

  // sequencer state and division index
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      op_sel <= OP_COL_FIRST;
    end else begin
      state <= state_next;
      if (s_acc) begin
        op_sel <= OP_COL_FIRST;
      end else if (state == ST_DIV_WAIT && div_done && op_sel != OP_ROW_FINAL) begin
        op_sel <= op_t'(op_sel + 2'd1);
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (s_acc) begin
          state_next = empty ? ST_EMIT : ST_DIV_ISSUE;
        end
      end
      ST_DIV_ISSUE: state_next = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (div_done) begin
          state_next = (op_sel == OP_ROW_FINAL) ? ST_EMIT : ST_DIV_ISSUE;
        end
      end
      ST_EMIT: begin
        if (m_acc && res.last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready      = 1'b0;
    m_tvalid      = 1'b0;
    div_start     = 1'b0;
    ctrl.start_fb = 1'b0;
    ctrl.fb_x     = s_tdata[4*COORD_W+CELL_W-1:4*COORD_W];
    ctrl.fb_y     = s_tdata[S_DATA_W-1:4*COORD_W+CELL_W];
    ctrl.load     = 1'b0;
    ctrl.op       = op_sel;
    ctrl.value    = div_quo;
    ctrl.advance  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready      = 1'b1;
        ctrl.start_fb = s_tvalid && empty;
      end
      ST_DIV_ISSUE: div_start = 1'b1;
      ST_DIV_WAIT:  ctrl.load = div_done;
      ST_EMIT: begin
        m_tvalid     = 1'b1;
        ctrl.advance = m_tready && !res.last;  // hold the cursor on the final cell
      end
      default: ;
    endcase
  end

  rgce_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num[op_sel]),
    .den   (cell_size),
    .done  (div_done),
    .quo   (div_quo)
  );

  rgce_scan #(
    .MAX_CELLS (MAX_CELLS)
  ) u_scan (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .res  (res)
  );

  assign m_tdata             = {res.y, res.x};
  assign m_tlast             = res.last;
  assign m_tuser[USER_FB]    = res.fb;
  assign m_tuser[USER_TRUNC] = res.trunc;

  // requests and results never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request taken while a result is pending");

  // a fallback result is always the only one
  a_fb_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_FB]) |-> m_tlast)
    else $error("fallback result not marked last");

  // truncation appears only on the final, non-fallback result
  a_trunc_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_TRUNC]) |-> (m_tlast && !m_tuser[USER_FB]))
    else $error("truncated flag on a non-final or fallback result");

  // the final result returns the block to idle
  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> s_tready)
    else $error("not idle after the final result");

endmodule
